// ----- design/bipm_pkg.sv -----
package bipm_pkg;

  // Field widths
  localparam int OP_W    = 3;
  localparam int MV_W    = 14;
  localparam int PCT_W   = 8;
  localparam int AVG_W   = 15;
  localparam int LVL_W   = 2;
  localparam int SCR_W   = 2;
  localparam int BL_W    = 8;
  localparam int PANEL_W = 2;
  localparam int IDLE_W  = 32;
  localparam int THR_W   = 7;
  localparam int SECS_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Operations
  localparam logic [OP_W-1:0] OP_TICK         = 3'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE       = 3'd1;
  localparam logic [OP_W-1:0] OP_ACTIVITY     = 3'd2;
  localparam logic [OP_W-1:0] OP_CHARGE_ENTER = 3'd3;
  localparam logic [OP_W-1:0] OP_CHARGE_EXIT  = 3'd4;
  localparam logic [OP_W-1:0] OP_APPLY        = 3'd5;

  // Charge levels
  localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOW    = 2'd1;
  localparam logic [LVL_W-1:0] LVL_CRIT   = 2'd2;

  // Screen states
  localparam logic [SCR_W-1:0] SCR_FULL   = 2'd0;
  localparam logic [SCR_W-1:0] SCR_DIM    = 2'd1;
  localparam logic [SCR_W-1:0] SCR_BLANK  = 2'd2;
  localparam logic [SCR_W-1:0] SCR_CHARGE = 2'd3;

  // Panel commands
  localparam logic [PANEL_W-1:0] PANEL_NONE  = 2'd0;
  localparam logic [PANEL_W-1:0] PANEL_WAKE  = 2'd1;
  localparam logic [PANEL_W-1:0] PANEL_SLEEP = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM_AFTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_AFTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_PCT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRIT_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_BL     = 3'd5;

  // Register reset values
  localparam logic [SECS_W-1:0] RST_DIM_AFTER   = 16'd120;
  localparam logic [SECS_W-1:0] RST_BLANK_AFTER = 16'd300;
  localparam logic [BL_W-1:0]   RST_DIM_PCT     = 8'd30;
  localparam logic [THR_W-1:0]  RST_LOW_THR     = 7'd20;
  localparam logic [THR_W-1:0]  RST_CRIT_THR    = 7'd10;
  localparam logic [BL_W-1:0]   RST_FULL_BL     = 8'd200;

  localparam logic signed [PCT_W-1:0] PCT_MAX  = 8'sd100;
  localparam logic signed [PCT_W-1:0] PCT_NONE = -8'sd1;
  localparam logic signed [AVG_W-1:0] AVG_NONE = -15'sd1;

  // 255/100 scaled by 2^19, rounded up
  localparam logic [20:0] DIM_RECIP = 21'd1336935;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [MV_W-1:0]         sample_mv;
    logic signed [PCT_W-1:0] sample_pct;
    logic                    radio_busy;
  } in_item_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average_mv;
    logic signed [PCT_W-1:0] battery_percent;
    logic [LVL_W-1:0]        charge_level;
    logic [SCR_W-1:0]        wanted_screen;
    logic [SCR_W-1:0]        shown_screen;
    logic                    charging_mode;
    logic                    stop_radio;
    logic                    backlight_write;
    logic [BL_W-1:0]         backlight_value;
    logic [PANEL_W-1:0]      panel_command;
    logic                    drawing_suppressed;
    logic [IDLE_W-1:0]       idle_seconds;
  } out_item_t;

  typedef struct packed {
    logic accept;     // latch the input item
    logic exec;       // apply the event to the state
    logic rd_issue;   // read the next ring entry
    logic sum_end;    // add the last entry, load the divider
    logic div_step;   // one quotient bit
    logic mean_load;  // store the quotient as the mean
    logic out_load;   // capture the result item
  } dp_cmd_t;

  typedef struct packed {
    logic need_mean;
    logic rd_last;
    logic div_last;
  } dp_sts_t;

  // min(pct,100) * 255 / 100 through a reciprocal multiply
  function automatic logic [BL_W-1:0] dim_level(input logic [BL_W-1:0] pct);
    logic [6:0]  p;
    logic [27:0] prod;
    p    = (pct > 8'd100) ? 7'd100 : pct[6:0];
    prod = 28'(p) * 28'(DIM_RECIP);
    return prod[26:19];
  endfunction

endpackage

// ----- design/bipm_in_if.sv -----
interface bipm_in_if import bipm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [MV_W-1:0]         sample_mv;
  logic signed [PCT_W-1:0] sample_pct;
  logic                    radio_busy;

  modport source (output valid, output operation, output sample_mv, output sample_pct,
                  output radio_busy, input ready);
  modport sink   (input valid, input operation, input sample_mv, input sample_pct,
                  input radio_busy, output ready);
endinterface

// ----- design/bipm_out_if.sv -----
interface bipm_out_if import bipm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average_mv;
  logic signed [PCT_W-1:0] battery_percent;
  logic [LVL_W-1:0]        charge_level;
  logic [SCR_W-1:0]        wanted_screen;
  logic [SCR_W-1:0]        shown_screen;
  logic                    charging_mode;
  logic                    stop_radio;
  logic                    backlight_write;
  logic [BL_W-1:0]         backlight_value;
  logic [PANEL_W-1:0]      panel_command;
  logic                    drawing_suppressed;
  logic [IDLE_W-1:0]       idle_seconds;

  modport source (output valid, output average_mv, output battery_percent,
                  output charge_level, output wanted_screen, output shown_screen,
                  output charging_mode, output stop_radio, output backlight_write,
                  output backlight_value, output panel_command, output drawing_suppressed,
                  output idle_seconds, input ready);
  modport sink   (input valid, input average_mv, input battery_percent,
                  input charge_level, input wanted_screen, input shown_screen,
                  input charging_mode, input stop_radio, input backlight_write,
                  input backlight_value, input panel_command, input drawing_suppressed,
                  input idle_seconds, output ready);
endinterface

// ----- design/bipm_ctrl.sv -----
module bipm_ctrl import bipm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SUMEND = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_MEAN   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_mean ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_SUMEND;
        end
      end
      S_SUMEND: begin
        cmd.sum_end = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_load = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/bipm_dp.sv -----
module bipm_dp import bipm_pkg::*; #(
  parameter int RING_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_item,
  output out_item_t             out_item
);

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = MV_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  // Configuration
  logic [SECS_W-1:0] dim_after_r, blank_after_r;
  logic [BL_W-1:0]   dim_pct_r, full_bl_r;
  logic [THR_W-1:0]  low_thr_r, crit_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_after_r   <= RST_DIM_AFTER;
      blank_after_r <= RST_BLANK_AFTER;
      dim_pct_r     <= RST_DIM_PCT;
      low_thr_r     <= RST_LOW_THR;
      crit_thr_r    <= RST_CRIT_THR;
      full_bl_r     <= RST_FULL_BL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_AFTER:   dim_after_r   <= cfg_wdata;
        REG_BLANK_AFTER: blank_after_r <= cfg_wdata;
        REG_DIM_PCT:     dim_pct_r     <= cfg_wdata[BL_W-1:0];
        REG_LOW_THR:     low_thr_r     <= cfg_wdata[THR_W-1:0];
        REG_CRIT_THR:    crit_thr_r    <= cfg_wdata[THR_W-1:0];
        REG_FULL_BL:     full_bl_r     <= cfg_wdata[BL_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched item
  in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_item;
    end
  end

  // Event state
  logic signed [AVG_W-1:0] mean_r;
  logic signed [PCT_W-1:0] pct_r, pct_nxt;
  logic [LVL_W-1:0]        level_r, level_nxt;
  logic [SCR_W-1:0]        desired_r, desired_nxt, applied_r, applied_nxt;
  logic                    charge_r, charge_nxt, shed_r, shed_nxt;
  logic [IDLE_W-1:0]       idle_r, idle_nxt;
  logic [IDX_W-1:0]        wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic                    stop_r, stop_nxt, blw_r, blw_nxt;
  logic [BL_W-1:0]         blv_r, blv_nxt;
  logic [PANEL_W-1:0]      panel_r, panel_nxt;
  logic                    mv_valid, pct_ok;
  logic signed [PCT_W-1:0] pct_sel;

  assign mv_valid      = (item_r.sample_mv != '0);
  assign sts.need_mean = (item_r.operation == OP_SAMPLE) && mv_valid;

  always_comb begin
    pct_nxt     = pct_r;
    level_nxt   = level_r;
    desired_nxt = desired_r;
    applied_nxt = applied_r;
    charge_nxt  = charge_r;
    shed_nxt    = shed_r;
    idle_nxt    = idle_r;
    wr_idx_nxt  = wr_idx_r;
    fill_nxt    = fill_r;
    stop_nxt    = 1'b0;
    blw_nxt     = 1'b0;
    blv_nxt     = '0;
    panel_nxt   = PANEL_NONE;
    pct_ok      = !item_r.sample_pct[PCT_W-1] && (item_r.sample_pct <= PCT_MAX);
    pct_sel     = pct_ok ? item_r.sample_pct : pct_r;
    unique case (item_r.operation)
      OP_TICK: begin
        if (idle_r != '1) begin
          idle_nxt = idle_r + 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (mv_valid) begin
          wr_idx_nxt = (wr_idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
          if (fill_r < CNT_W'(RING_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
        end
        pct_nxt = pct_sel;
        priority if (pct_sel <= $signed({1'b0, crit_thr_r})) begin
          level_nxt = LVL_CRIT;
        end else if (pct_sel <= $signed({1'b0, low_thr_r})) begin
          level_nxt = LVL_LOW;
        end else begin
          level_nxt = LVL_NORMAL;
        end
        if (level_nxt == LVL_CRIT) begin
          if (!shed_r) begin
            stop_nxt = item_r.radio_busy;
            shed_nxt = 1'b1;
          end
        end else begin
          shed_nxt = 1'b0;
        end
        if (!charge_r) begin
          priority if ((blank_after_r != '0) && (idle_r >= IDLE_W'(blank_after_r))) begin
            desired_nxt = SCR_BLANK;
          end else if ((dim_after_r != '0) && (idle_r >= IDLE_W'(dim_after_r))) begin
            desired_nxt = SCR_DIM;
          end else begin
            desired_nxt = SCR_FULL;
          end
        end
      end
      OP_ACTIVITY: begin
        idle_nxt    = '0;
        charge_nxt  = 1'b0;
        desired_nxt = SCR_FULL;
      end
      OP_CHARGE_ENTER: begin
        if (!charge_r) begin
          charge_nxt  = 1'b1;
          stop_nxt    = item_r.radio_busy;
          desired_nxt = SCR_CHARGE;
        end
      end
      OP_CHARGE_EXIT: begin
        if (charge_r) begin
          charge_nxt  = 1'b0;
          idle_nxt    = '0;
          desired_nxt = SCR_FULL;
        end
      end
      OP_APPLY: begin
        if (desired_r != applied_r) begin
          blw_nxt     = 1'b1;
          applied_nxt = desired_r;
          unique case (desired_r)
            SCR_FULL: begin
              panel_nxt = PANEL_WAKE;
              blv_nxt   = full_bl_r;
            end
            SCR_DIM:   blv_nxt = dim_level(dim_pct_r);
            SCR_BLANK: blv_nxt = '0;
            default: begin
              blv_nxt   = '0;
              panel_nxt = PANEL_SLEEP;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Ring mean: sum the filled entries, then divide by the fill count
  logic [MV_W-1:0]   ring_mem [RING_DEPTH];
  logic [MV_W-1:0]   rd_data_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [SUM_W-1:0]  sum_r, quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]    rem_shift;
  logic              div_ge;

  assign sts.rd_last  = (CNT_W'(rd_idx_r) == fill_r - 1'b1);
  assign sts.div_last = (div_cnt_r == DCNT_W'(SUM_W - 1));
  assign rem_shift    = {rem_r, quo_r[SUM_W-1]};
  assign div_ge       = (rem_shift >= {1'b0, fill_r});

  always_ff @(posedge clk) begin
    if (cmd.exec && sts.need_mean) begin
      ring_mem[wr_idx_r] <= item_r.sample_mv;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= ring_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_idx_r <= '0;
      sum_r    <= '0;
    end else begin
      if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (rd_vld_r && !cmd.sum_end) begin
        sum_r <= sum_r + SUM_W'(rd_data_r);
      end
    end
    if (cmd.sum_end) begin
      quo_r     <= sum_r + SUM_W'(rd_data_r);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[SUM_W-2:0], div_ge};
      rem_r     <= div_ge ? CNT_W'(rem_shift - {1'b0, fill_r}) : rem_r[CNT_W-1:0] << 1
                   | CNT_W'(quo_r[SUM_W-1]);
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r    <= AVG_NONE;
      pct_r     <= PCT_NONE;
      level_r   <= LVL_NORMAL;
      desired_r <= SCR_FULL;
      applied_r <= SCR_FULL;
      charge_r  <= 1'b0;
      shed_r    <= 1'b0;
      idle_r    <= '0;
      wr_idx_r  <= '0;
      fill_r    <= '0;
    end else begin
      if (cmd.exec) begin
        pct_r     <= pct_nxt;
        level_r   <= level_nxt;
        desired_r <= desired_nxt;
        applied_r <= applied_nxt;
        charge_r  <= charge_nxt;
        shed_r    <= shed_nxt;
        idle_r    <= idle_nxt;
        wr_idx_r  <= wr_idx_nxt;
        fill_r    <= fill_nxt;
      end
      if (cmd.mean_load) begin
        mean_r <= $signed({1'b0, quo_r[MV_W-1:0]});
      end
    end
  end

  // Per-item strobes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      stop_r  <= stop_nxt;
      blw_r   <= blw_nxt;
      blv_r   <= blv_nxt;
      panel_r <= panel_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.average_mv         <= mean_r;
      out_item.battery_percent    <= pct_r;
      out_item.charge_level       <= level_r;
      out_item.wanted_screen      <= desired_r;
      out_item.shown_screen       <= applied_r;
      out_item.charging_mode      <= charge_r;
      out_item.stop_radio         <= stop_r;
      out_item.backlight_write    <= blw_r;
      out_item.backlight_value    <= blv_r;
      out_item.panel_command      <= panel_r;
      out_item.drawing_suppressed <= (desired_r == SCR_BLANK) || (desired_r == SCR_CHARGE);
      out_item.idle_seconds       <= idle_r;
    end
  end

endmodule

// ----- design/battery_idle_power_manager.sv -----
// Battery and idle power manager: takes one timed event per item (second tick, battery
// sample, activity, charge enter/exit, screen apply) and returns one status item with the
// ring mean of the battery millivolts, the stored percent and its level, the desired and
// applied screen states, and the stop-radio, backlight and panel strobes for that event.
// Items are handled one at a time. A non-sample event, or a sample with zero millivolts,
// goes from acceptance straight to the result. A sample with nonzero millivolts also
// sums the ring entries in use (fill, 1 to RING_DEPTH) and divides the sum by fill,
// with SUM_W = 14 + clog2(RING_DEPTH + 1) quotient bits: the single-port ring is read
// one entry a cycle for the sum, and a restoring divider produces one quotient bit a cycle.
// A finished item waits in the output register while the next item is taken;
// configuration writes take effect at once.
module battery_idle_power_manager import bipm_pkg::*; #(
  parameter int RING_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bipm_in_if.sink               in_chan,
  bipm_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  in_item_t  in_item;
  out_item_t out_item;

  // Gather the input item
  assign in_item.operation  = in_chan.operation;
  assign in_item.sample_mv  = in_chan.sample_mv;
  assign in_item.sample_pct = in_chan.sample_pct;
  assign in_item.radio_busy = in_chan.radio_busy;

  // Sequence the event: accept, apply, sum the ring, divide, deliver
  bipm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold state, ring, divider and the result register
  bipm_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item)
  );

  // Drive the result item
  assign out_chan.average_mv         = out_item.average_mv;
  assign out_chan.battery_percent    = out_item.battery_percent;
  assign out_chan.charge_level       = out_item.charge_level;
  assign out_chan.wanted_screen      = out_item.wanted_screen;
  assign out_chan.shown_screen       = out_item.shown_screen;
  assign out_chan.charging_mode      = out_item.charging_mode;
  assign out_chan.stop_radio         = out_item.stop_radio;
  assign out_chan.backlight_write    = out_item.backlight_write;
  assign out_chan.backlight_value    = out_item.backlight_value;
  assign out_chan.panel_command      = out_item.panel_command;
  assign out_chan.drawing_suppressed = out_item.drawing_suppressed;
  assign out_chan.idle_seconds       = out_item.idle_seconds;

  // A panel command only comes with a backlight write
  a_panel_with_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.panel_command != PANEL_NONE) |-> out_chan.backlight_write)
    else $error("panel command without backlight write");

  // Suppressed drawing follows the desired screen
  a_suppress_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.drawing_suppressed ==
      ((out_chan.wanted_screen == SCR_BLANK) || (out_chan.wanted_screen == SCR_CHARGE))))
    else $error("drawing_suppressed does not match wanted_screen");

  // One item at a time: no acceptance right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input ready right after an accepted item");

  // The result register is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result overwritten before it was taken");

endmodule
